// File: hdl/pwftx_pkg.sv
package pwftx_pkg;

	localparam int DELAY_COUNTER_BITS = 16;
	localparam int FRAME_LEN = 12;
	localparam int FRAME_BITS = FRAME_LEN * 8;
	localparam int BIT_IDX_W = $clog2(FRAME_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [7:0] VOLT_OFFSET = 8'd185;
	localparam logic [12:0] KELVIN_OFFSET = 13'd2731;
	localparam logic [16:0] RECIP10 = 17'd52429;
	localparam logic [31:0] LEN_CAP = (32'd1 << DELAY_COUNTER_BITS) - 32'd1;

	localparam logic [15:0] SYNC_LOW_RST = 16'd16000;
	localparam logic [15:0] SYNC_HIGH_RST = 16'd500;
	localparam logic [15:0] SHORT_RST = 16'd500;
	localparam logic [15:0] LONG_RST = 16'd1000;
	localparam logic [7:0] DEVICE_ID_RST = 8'h03;
	localparam logic [7:0] COMMAND_RST = 8'h01;

	typedef enum logic [2:0] {
		REG_SYNC_LOW  = 3'd0,
		REG_SYNC_HIGH = 3'd1,
		REG_SHORT     = 3'd2,
		REG_LONG      = 3'd3,
		REG_DEVICE_ID = 3'd4,
		REG_COMMAND   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC_LOW,
		PH_SYNC_HIGH,
		PH_BIT_LOW,
		PH_BIT_HIGH
	} phase_t;

	typedef struct packed {
		logic [15:0] sync_low_ticks;
		logic [15:0] sync_high_ticks;
		logic [15:0] short_ticks;
		logic [15:0] long_ticks;
		logic [7:0]  device_id;
		logic [7:0]  command_code;
	} cfg_t;

	typedef struct packed {
		logic                  send;
		logic [FRAME_BITS-1:0] frame;
	} cmd_t;

	typedef struct packed {
		logic step;
		logic idle;
		logic send;
	} bk_status_t;

	function automatic logic [DELAY_COUNTER_BITS-1:0] eff_len(input logic [15:0] r);
		logic [31:0] v;
		v = 32'(r);
		if (v == 32'd0) begin
			v = 32'd1;
		end
		if (v > LEN_CAP) begin
			v = LEN_CAP;
		end
		return v[DELAY_COUNTER_BITS-1:0];
	endfunction

	// exact for x < 43690
	function automatic logic [9:0] div10(input logic [12:0] x);
		logic [29:0] p;
		p = 30'(x) * 30'(RECIP10);
		return p[28:19];
	endfunction

endpackage

// File: hdl/pwftx_if.sv
interface pwftx_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  err_status;
	logic [12:0] cell_vmax_mv;
	logic [12:0] cell_vmin_mv;
	logic [11:0] cell_tmax_dk;
	logic [11:0] cell_tmin_dk;
	logic [9:0]  soc_permille;
	logic [9:0]  soh_permille;
	logic [15:0] cycle_count;

	modport source (output valid, func, err_status, cell_vmax_mv, cell_vmin_mv,
		cell_tmax_dk, cell_tmin_dk, soc_permille, soh_permille, cycle_count,
		input ready);
	modport sink (input valid, func, err_status, cell_vmax_mv, cell_vmin_mv,
		cell_tmax_dk, cell_tmin_dk, soc_permille, soh_permille, cycle_count,
		output ready);
endinterface

interface pwftx_result_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic frame_done;
	logic rejected;

	modport source (output valid, line_level, busy_res, frame_done, rejected,
		input ready);
	modport sink (input valid, line_level, busy_res, frame_done, rejected,
		output ready);
endinterface

// File: hdl/pwftx_regs.sv
module pwftx_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pwftx_pkg::PADDR_W-1:0]   paddr,
	input  logic [pwftx_pkg::PDATA_W-1:0]   pwdata,
	output logic [pwftx_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output pwftx_pkg::cfg_t                 cfg
);

	pwftx_pkg::cfg_t   cfg_q;
	pwftx_pkg::reg_idx_t idx;
	logic              wr;

	assign idx = pwftx_pkg::reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_low_ticks <= pwftx_pkg::SYNC_LOW_RST;
			cfg_q.sync_high_ticks <= pwftx_pkg::SYNC_HIGH_RST;
			cfg_q.short_ticks <= pwftx_pkg::SHORT_RST;
			cfg_q.long_ticks <= pwftx_pkg::LONG_RST;
			cfg_q.device_id <= pwftx_pkg::DEVICE_ID_RST;
			cfg_q.command_code <= pwftx_pkg::COMMAND_RST;
		end else if (wr) begin
			case (idx)
				pwftx_pkg::REG_SYNC_LOW: cfg_q.sync_low_ticks <= pwdata[15:0];
				pwftx_pkg::REG_SYNC_HIGH: cfg_q.sync_high_ticks <= pwdata[15:0];
				pwftx_pkg::REG_SHORT: cfg_q.short_ticks <= pwdata[15:0];
				pwftx_pkg::REG_LONG: cfg_q.long_ticks <= pwdata[15:0];
				pwftx_pkg::REG_DEVICE_ID: cfg_q.device_id <= pwdata[7:0];
				pwftx_pkg::REG_COMMAND: cfg_q.command_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pwftx_pkg::REG_SYNC_LOW: prdata = 32'(cfg_q.sync_low_ticks);
			pwftx_pkg::REG_SYNC_HIGH: prdata = 32'(cfg_q.sync_high_ticks);
			pwftx_pkg::REG_SHORT: prdata = 32'(cfg_q.short_ticks);
			pwftx_pkg::REG_LONG: prdata = 32'(cfg_q.long_ticks);
			pwftx_pkg::REG_DEVICE_ID: prdata = 32'(cfg_q.device_id);
			pwftx_pkg::REG_COMMAND: prdata = 32'(cfg_q.command_code);
			default: prdata = '0;
		endcase
	end

endmodule

// File: hdl/pwftx_front.sv
module pwftx_front (
	input  logic            clk,
	input  logic            arst_n,
	pwftx_item_if.sink      item,
	input  pwftx_pkg::cfg_t cfg,
	input  logic            q_full,
	output logic            q_push,
	output pwftx_pkg::cmd_t q_wdata
);

	logic        valid_s1;
	logic        send_s1;
	logic [7:0]  err_s1;
	logic [9:0]  vmax_s1;
	logic [9:0]  vmin_s1;
	logic [9:0]  soc_s1;
	logic [9:0]  soh_s1;
	logic [9:0]  tmax_s1;
	logic [9:0]  tmin_s1;
	logic        tmax_neg_s1;
	logic        tmin_neg_s1;
	logic [15:0] cyc_s1;

	logic [12:0] tmax_d;
	logic [12:0] tmin_d;
	logic [12:0] tmax_mag;
	logic [12:0] tmin_mag;
	logic        take;
	logic [7:0]  b [pwftx_pkg::FRAME_LEN];
	logic [7:0]  sum;

	assign item.ready = !valid_s1 || !q_full;
	assign take = item.valid && item.ready;
	assign q_push = valid_s1 && !q_full;

	// offset from 273.1 K, then magnitude so the quotient truncates toward zero
	assign tmax_d = 13'(item.cell_tmax_dk) - pwftx_pkg::KELVIN_OFFSET;
	assign tmin_d = 13'(item.cell_tmin_dk) - pwftx_pkg::KELVIN_OFFSET;
	assign tmax_mag = tmax_d[12] ? 13'(13'd0 - tmax_d) : tmax_d;
	assign tmin_mag = tmin_d[12] ? 13'(13'd0 - tmin_d) : tmin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			send_s1 <= item.func;
			err_s1 <= item.err_status;
			vmax_s1 <= pwftx_pkg::div10(item.cell_vmax_mv);
			vmin_s1 <= pwftx_pkg::div10(item.cell_vmin_mv);
			soc_s1 <= pwftx_pkg::div10(13'(item.soc_permille));
			soh_s1 <= pwftx_pkg::div10(13'(item.soh_permille));
			tmax_s1 <= pwftx_pkg::div10(tmax_mag);
			tmin_s1 <= pwftx_pkg::div10(tmin_mag);
			tmax_neg_s1 <= tmax_d[12];
			tmin_neg_s1 <= tmin_d[12];
			cyc_s1 <= item.cycle_count;
		end
	end

	always_comb begin
		b[0] = cfg.device_id;
		b[1] = cfg.command_code;
		b[2] = err_s1;
		b[3] = vmax_s1[7:0] - pwftx_pkg::VOLT_OFFSET;
		b[4] = soc_s1[7:0];
		b[5] = soh_s1[7:0];
		b[6] = tmax_neg_s1 ? 8'(8'd0 - tmax_s1[7:0]) : tmax_s1[7:0];
		b[7] = tmin_neg_s1 ? 8'(8'd0 - tmin_s1[7:0]) : tmin_s1[7:0];
		b[8] = cyc_s1[15:8];
		b[9] = cyc_s1[7:0];
		b[10] = vmin_s1[7:0] - pwftx_pkg::VOLT_OFFSET;
		sum = '0;
		for (int i = 0; i < pwftx_pkg::FRAME_LEN - 1; i++) begin
			sum = sum ^ b[i];
		end
		b[11] = sum;
	end

	// byte 0 in the top bits, MSB first on the line
	always_comb begin
		q_wdata.send = send_s1;
		for (int i = 0; i < pwftx_pkg::FRAME_LEN; i++) begin
			q_wdata.frame[pwftx_pkg::FRAME_BITS-1-8*i -: 8] = b[i];
		end
	end

endmodule

// File: hdl/pwftx_queue.sv
module pwftx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pwftx_pkg::cmd_t wdata,
	input  logic            pop,
	output pwftx_pkg::cmd_t rdata,
	output logic            full,
	output logic            empty
);

	pwftx_pkg::cmd_t mem [pwftx_pkg::QUEUE_DEPTH];
	logic [pwftx_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [pwftx_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [pwftx_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full = count_q == pwftx_pkg::QUEUE_CNT_W'(pwftx_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pwftx_pkg::QUEUE_PTR_W'(pwftx_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pwftx_pkg::QUEUE_PTR_W'(pwftx_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/pwftx_back.sv
module pwftx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwftx_pkg::cfg_t       cfg,
	input  pwftx_pkg::cmd_t       cmd,
	input  logic                  q_empty,
	output logic                  q_pop,
	output pwftx_pkg::bk_status_t status,
	pwftx_result_if.source        result
);

	localparam int CW = pwftx_pkg::DELAY_COUNTER_BITS;

	pwftx_pkg::phase_t                   phase_q, phase_d;
	logic [CW-1:0]                       count_q, count_d;
	logic [pwftx_pkg::BIT_IDX_W-1:0]     idx_q, idx_d;
	logic [pwftx_pkg::FRAME_BITS-1:0]    frame_q, frame_d;

	logic          out_valid_q;
	logic          level_q, busy_q, done_q, rej_q;
	logic          level, busy, done, rej;
	logic          idle, cur_bit, level_now, ends, last;
	logic [CW-1:0] len;
	logic [CW:0]   cnt_inc;

	assign q_pop = !q_empty && (!out_valid_q || result.ready);
	assign idle = phase_q == pwftx_pkg::PH_IDLE;
	assign cur_bit = frame_q[pwftx_pkg::FRAME_BITS-1];
	assign level_now = !(phase_q == pwftx_pkg::PH_SYNC_LOW || phase_q == pwftx_pkg::PH_BIT_LOW);
	assign cnt_inc = {1'b0, count_q} + 1'b1;
	assign ends = cnt_inc >= {1'b0, len};
	assign last = idx_q == pwftx_pkg::BIT_IDX_W'(pwftx_pkg::FRAME_BITS - 1);

	assign status.step = q_pop;
	assign status.idle = idle;
	assign status.send = cmd.send;

	always_comb begin
		case (phase_q)
			pwftx_pkg::PH_SYNC_LOW: len = pwftx_pkg::eff_len(cfg.sync_low_ticks);
			pwftx_pkg::PH_SYNC_HIGH: len = pwftx_pkg::eff_len(cfg.sync_high_ticks);
			pwftx_pkg::PH_BIT_LOW:
				len = pwftx_pkg::eff_len(cur_bit ? cfg.short_ticks : cfg.long_ticks);
			default: len = pwftx_pkg::eff_len(cur_bit ? cfg.long_ticks : cfg.short_ticks);
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		idx_d = idx_q;
		frame_d = frame_q;
		if (cmd.send) begin
			if (idle) begin
				phase_d = pwftx_pkg::PH_SYNC_LOW;
				count_d = '0;
				idx_d = '0;
				frame_d = cmd.frame;
			end
		end else if (!idle) begin
			count_d = ends ? '0 : cnt_inc[CW-1:0];
			if (ends) begin
				case (phase_q)
					pwftx_pkg::PH_SYNC_LOW: phase_d = pwftx_pkg::PH_SYNC_HIGH;
					pwftx_pkg::PH_SYNC_HIGH: phase_d = pwftx_pkg::PH_BIT_LOW;
					pwftx_pkg::PH_BIT_LOW: phase_d = pwftx_pkg::PH_BIT_HIGH;
					pwftx_pkg::PH_BIT_HIGH: begin
						if (last) begin
							idx_d = '0;
							phase_d = pwftx_pkg::PH_IDLE;
						end else begin
							idx_d = idx_q + 1'b1;
							phase_d = pwftx_pkg::PH_BIT_LOW;
							frame_d = {frame_q[pwftx_pkg::FRAME_BITS-2:0], 1'b0};
						end
					end
					default: phase_d = pwftx_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// result word
	always_comb begin
		level = 1'b1;
		busy = 1'b0;
		done = 1'b0;
		rej = 1'b0;
		if (cmd.send) begin
			rej = !idle;
			level = idle ? 1'b0 : level_now;
			busy = 1'b1;
		end else if (!idle) begin
			level = level_now;
			busy = 1'b1;
			done = phase_q == pwftx_pkg::PH_BIT_HIGH && ends && last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pwftx_pkg::PH_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d;
				count_q <= count_d;
				idx_q <= idx_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= frame_d;
			level_q <= level;
			busy_q <= busy;
			done_q <= done;
			rej_q <= rej;
		end
	end

	assign result.valid = out_valid_q;
	assign result.line_level = level_q;
	assign result.busy_res = busy_q;
	assign result.frame_done = done_q;
	assign result.rejected = rej_q;

endmodule

// File: hdl/pulse_width_one_wire_frame_tx_core.sv
// One-wire pulse-width frame transmitter for battery readings.
// item channel: func 1 is a send word carrying the readings, func 0 is one
// microsecond tick. Every word gives exactly one result word on the result
// channel (line_level, busy_res, frame_done, rejected), in order.
// A send while idle latches a 12-byte frame (id, command, status, scaled
// readings, XOR checksum) and starts the sync low phase; a send while busy
// only reports rejected. Ticks then walk the sync low, sync high and 96 bit
// cells, MSB first; phase lengths come from the APB registers.
// Path: front register, 2-entry queue, back output register, which holds
// the result word. Throughput: one word per cycle while the result channel
// is ready, set by the back sequencer handling one queued word per cycle.
// Reset: line idle (high), queue empty, registers at their defaults; no
// frame is stored until the first send.
// Result stall: the output register holds its word, the back waits, the
// queue fills, then the front drops item.ready; nothing is lost. The user
// must write configuration only while no word is in flight (not enforced).
module pulse_width_one_wire_frame_tx_core (
	input  logic                          clk,
	input  logic                          arst_n,
	pwftx_item_if.sink                    item,
	pwftx_result_if.source                result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pwftx_pkg::PADDR_W-1:0] paddr,
	input  logic [pwftx_pkg::PDATA_W-1:0] pwdata,
	output logic [pwftx_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);

	pwftx_pkg::cfg_t       cfg;
	pwftx_pkg::cmd_t       q_wdata;
	pwftx_pkg::cmd_t       q_rdata;
	pwftx_pkg::bk_status_t bk_status;
	logic                  q_push, q_pop, q_full, q_empty;

	pwftx_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwftx_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	pwftx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	pwftx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.status  (bk_status),
		.result  (result)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_done |-> result.busy_res && !result.rejected)
		else $error("frame_done without busy or with rejected");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.step && bk_status.idle && !bk_status.send
		|=> result.valid && result.line_level && !result.busy_res)
		else $error("idle tick did not give a high idle line");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

endmodule

// File: tb/pulse_width_one_wire_frame_tx_core_test.sv
module pulse_width_one_wire_frame_tx_core_test;

	localparam int RANDOM_WORDS = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int VOLT_BIAS = 185;
	localparam int ZERO_C_DK = 2731;
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SEND = 1'b1;

	typedef struct packed {
		logic        func;
		logic [7:0]  err_status;
		logic [12:0] cell_vmax_mv;
		logic [12:0] cell_vmin_mv;
		logic [11:0] cell_tmax_dk;
		logic [11:0] cell_tmin_dk;
		logic [9:0]  soc_permille;
		logic [9:0]  soh_permille;
		logic [15:0] cycle_count;
	} reading_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} line_res_t;

	typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PATTERN, RX_HEAVY} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pwftx_pkg::PADDR_W-1:0] paddr = '0;
	logic [pwftx_pkg::PDATA_W-1:0] pwdata = '0;
	logic [pwftx_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic drv_valid = 1'b0;
	reading_t drv_word = '0;
	logic rx_ready = 1'b0;

	pwftx_item_if item_ch();
	pwftx_result_if result_ch();

	assign item_ch.valid = drv_valid;
	assign item_ch.func = drv_word.func;
	assign item_ch.err_status = drv_word.err_status;
	assign item_ch.cell_vmax_mv = drv_word.cell_vmax_mv;
	assign item_ch.cell_vmin_mv = drv_word.cell_vmin_mv;
	assign item_ch.cell_tmax_dk = drv_word.cell_tmax_dk;
	assign item_ch.cell_tmin_dk = drv_word.cell_tmin_dk;
	assign item_ch.soc_permille = drv_word.soc_permille;
	assign item_ch.soh_permille = drv_word.soh_permille;
	assign item_ch.cycle_count = drv_word.cycle_count;
	assign result_ch.ready = rx_ready;

	pulse_width_one_wire_frame_tx_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// line model state
	pwftx_pkg::cfg_t line_cfg;
	logic [pwftx_pkg::FRAME_BITS-1:0] tx_frame = '0;
	int tx_bit = 0;
	pwftx_pkg::phase_t tx_phase = pwftx_pkg::PH_IDLE;
	int tx_count = 0;

	reading_t pending_words[$];
	line_res_t line_expect[$];

	int words_queued = 0;
	int words_checked = 0;
	int mismatch_count = 0;
	int frames_done = 0;
	int rejects_seen = 0;
	int settings_used = 0;
	int tx_burst_left = 0;
	int tx_gap_left = 0;
	int rx_mode_left = 0;
	stall_mode_t rx_mode = RX_OPEN;
	logic [2:0] rx_beat = '0;

	always #10 clk = ~clk;

	function automatic int ticks_of(logic [15:0] r);
		return (r == 16'd0) ? 1 : int'(r);
	endfunction

	function automatic int frame_ticks();
		return ticks_of(line_cfg.sync_low_ticks) + ticks_of(line_cfg.sync_high_ticks) +
			pwftx_pkg::FRAME_BITS *
			(ticks_of(line_cfg.short_ticks) + ticks_of(line_cfg.long_ticks));
	endfunction

	function automatic logic level_of(pwftx_pkg::phase_t p);
		return !(p == pwftx_pkg::PH_SYNC_LOW || p == pwftx_pkg::PH_BIT_LOW);
	endfunction

	function automatic logic [pwftx_pkg::FRAME_BITS-1:0] build_frame(reading_t w);
		logic [7:0] b [pwftx_pkg::FRAME_LEN];
		logic [7:0] chk;
		logic [pwftx_pkg::FRAME_BITS-1:0] f;
		b[0] = line_cfg.device_id;
		b[1] = line_cfg.command_code;
		b[2] = w.err_status;
		b[3] = 8'(int'(w.cell_vmax_mv) / 10 - VOLT_BIAS);
		b[4] = 8'(int'(w.soc_permille) / 10);
		b[5] = 8'(int'(w.soh_permille) / 10);
		// signed division truncates toward zero below 0 C
		b[6] = 8'((int'(w.cell_tmax_dk) - ZERO_C_DK) / 10);
		b[7] = 8'((int'(w.cell_tmin_dk) - ZERO_C_DK) / 10);
		b[8] = w.cycle_count[15:8];
		b[9] = w.cycle_count[7:0];
		b[10] = 8'(int'(w.cell_vmin_mv) / 10 - VOLT_BIAS);
		chk = '0;
		for (int i = 0; i < pwftx_pkg::FRAME_LEN - 1; i++) begin
			chk ^= b[i];
		end
		b[11] = chk;
		f = '0;
		for (int i = 0; i < pwftx_pkg::FRAME_LEN; i++) begin
			f[pwftx_pkg::FRAME_BITS-1-8*i -: 8] = b[i];
		end
		return f;
	endfunction

	task automatic predict_line(input reading_t w, output line_res_t r);
		int lim;
		logic one;
		r = '0;
		if (w.func == FUNC_SEND) begin
			if (tx_phase != pwftx_pkg::PH_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				tx_frame = build_frame(w);
				tx_bit = 0;
				tx_count = 0;
				tx_phase = pwftx_pkg::PH_SYNC_LOW;
			end
			r.line_level = level_of(tx_phase);
			r.busy_res = (tx_phase != pwftx_pkg::PH_IDLE);
		end else if (tx_phase == pwftx_pkg::PH_IDLE) begin
			r.line_level = 1'b1;
		end else begin
			one = tx_frame[pwftx_pkg::FRAME_BITS-1-tx_bit];
			case (tx_phase)
				pwftx_pkg::PH_SYNC_LOW: lim = ticks_of(line_cfg.sync_low_ticks);
				pwftx_pkg::PH_SYNC_HIGH: lim = ticks_of(line_cfg.sync_high_ticks);
				pwftx_pkg::PH_BIT_LOW:
					lim = ticks_of(one ? line_cfg.short_ticks : line_cfg.long_ticks);
				default: lim = ticks_of(one ? line_cfg.long_ticks : line_cfg.short_ticks);
			endcase
			r.line_level = level_of(tx_phase);
			r.busy_res = 1'b1;
			tx_count++;
			if (tx_count >= lim) begin
				tx_count = 0;
				case (tx_phase)
					pwftx_pkg::PH_SYNC_LOW: tx_phase = pwftx_pkg::PH_SYNC_HIGH;
					pwftx_pkg::PH_SYNC_HIGH: tx_phase = pwftx_pkg::PH_BIT_LOW;
					pwftx_pkg::PH_BIT_LOW: tx_phase = pwftx_pkg::PH_BIT_HIGH;
					default: begin
						if (tx_bit + 1 >= pwftx_pkg::FRAME_BITS) begin
							tx_bit = 0;
							tx_phase = pwftx_pkg::PH_IDLE;
							r.frame_done = 1'b1;
						end else begin
							tx_bit++;
							tx_phase = pwftx_pkg::PH_BIT_LOW;
						end
					end
				endcase
			end
		end
	endtask

	task automatic check_field(string name, logic exp_v, logic got_v);
		if (got_v !== exp_v) begin
			$error("%s expected %0b got %0b", name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// sender: bursts of words with random gaps
	always @(posedge clk) begin : item_drv
		line_res_t want;
		if (arst_n) begin
			if (drv_valid && item_ch.ready) begin
				predict_line(drv_word, want);
				line_expect.push_back(want);
			end
			if (!drv_valid || item_ch.ready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					drv_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					drv_word <= pending_words.pop_front();
					drv_valid <= 1'b1;
					if (tx_burst_left <= 1) begin
						tx_burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(100, 400) : $urandom_range(1, 24);
						tx_gap_left = $urandom_range(0, 4);
					end else begin
						tx_burst_left--;
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks words and stalls by mode
	always @(posedge clk) begin : result_mon
		line_res_t got;
		line_res_t want;
		if (arst_n) begin
			if (result_ch.valid && rx_ready) begin
				got = '{result_ch.line_level, result_ch.busy_res, result_ch.frame_done,
					result_ch.rejected};
				words_checked++;
				if (got.frame_done === 1'b1) frames_done++;
				if (got.rejected === 1'b1) rejects_seen++;
				if (line_expect.size() == 0) begin
					$error("result word with nothing expected");
					mismatch_count++;
				end else begin
					want = line_expect.pop_front();
					check_field("line_level", want.line_level, got.line_level);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("frame_done", want.frame_done, got.frame_done);
					check_field("rejected", want.rejected, got.rejected);
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode = stall_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(16, 300);
			end else begin
				rx_mode_left--;
			end
			rx_beat++;
			case (rx_mode)
				RX_OPEN: rx_ready <= 1'b1;
				RX_SPARSE: rx_ready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: rx_ready <= (rx_beat < 3'd5);
				default: rx_ready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	task automatic reg_write(pwftx_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pwftx_pkg::PADDR_W'(4 * int'(idx));
		pwdata <= pwftx_pkg::PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pwftx_pkg::REG_SYNC_LOW: line_cfg.sync_low_ticks = val;
			pwftx_pkg::REG_SYNC_HIGH: line_cfg.sync_high_ticks = val;
			pwftx_pkg::REG_SHORT: line_cfg.short_ticks = val;
			pwftx_pkg::REG_LONG: line_cfg.long_ticks = val;
			pwftx_pkg::REG_DEVICE_ID: line_cfg.device_id = val[7:0];
			default: line_cfg.command_code = val[7:0];
		endcase
	endtask

	task automatic set_config(int sl, int sh, int sp, int lp, int id, int cmd);
		reg_write(pwftx_pkg::REG_SYNC_LOW, 16'(sl));
		reg_write(pwftx_pkg::REG_SYNC_HIGH, 16'(sh));
		reg_write(pwftx_pkg::REG_SHORT, 16'(sp));
		reg_write(pwftx_pkg::REG_LONG, 16'(lp));
		reg_write(pwftx_pkg::REG_DEVICE_ID, 16'(id));
		reg_write(pwftx_pkg::REG_COMMAND, 16'(cmd));
		settings_used++;
		@(negedge clk);
	endtask

	function automatic int field_val(int bits, int hi);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return hi;
			2: return int'($urandom_range(0, (1 << bits) - 1));
			default: return int'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic reading_t random_reading(logic f);
		reading_t w;
		w.func = f;
		w.err_status = 8'($urandom);
		w.cell_vmax_mv = 13'(field_val(13, 6000));
		w.cell_vmin_mv = 13'(field_val(13, 6000));
		w.cell_tmax_dk = 12'(field_val(12, 4000));
		w.cell_tmin_dk = 12'(field_val(12, 4000));
		w.soc_permille = 10'(field_val(10, 1000));
		w.soh_permille = 10'(field_val(10, 1000));
		w.cycle_count = 16'($urandom);
		return w;
	endfunction

	function automatic int rand_len();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
	endfunction

	function automatic int rand_byte();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic queue_word(reading_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_ticks(int n);
		repeat (n) queue_word(random_reading(FUNC_TICK));
	endtask

	// a send followed by exactly enough ticks to finish it, with stray sends mixed in
	task automatic queue_frame(reading_t w);
		int n;
		int k;
		n = frame_ticks();
		queue_word(w);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 31) == 0 || (k == n - 1 && $urandom_range(0, 1) == 0)) begin
				queue_word(random_reading(FUNC_SEND));
			end
			queue_word(random_reading(FUNC_TICK));
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || drv_valid || line_expect.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int start;
		reading_t w;
		reading_t w_max;
		reading_t w_cold;
		line_cfg = '{16'd16000, 16'd500, 16'd500, 16'd1000, 8'h03, 8'h01};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		w_max = '{func: FUNC_SEND, err_status: 8'hFF, cell_vmax_mv: 13'd6000,
			cell_vmin_mv: 13'd6000, cell_tmax_dk: 12'd4000, cell_tmin_dk: 12'd0,
			soc_permille: 10'd1000, soh_permille: 10'd1000, cycle_count: 16'hFFFF};
		// just below and at the zero points of the voltage and temperature bytes
		w_cold = '{func: FUNC_SEND, err_status: 8'h80, cell_vmax_mv: 13'd1849,
			cell_vmin_mv: 13'd1850, cell_tmax_dk: 12'd2725, cell_tmin_dk: 12'd2721,
			soc_permille: 10'd999, soh_permille: 10'd5, cycle_count: 16'h00FF};

		// reset lengths and ids, sends while busy
		queue_ticks(2);
		queue_word(w_max);
		w = '1;
		queue_word(w);
		w = '0;
		w.func = FUNC_SEND;
		queue_word(w);
		queue_ticks(20);
		wait_drained();

		// zero-length phases finish the reset-length frame early
		set_config(0, 1, 0, 1, 255, 0);
		queue_ticks(frame_ticks());
		queue_ticks(1);
		wait_drained();

		queue_frame(w_cold);
		queue_ticks(1);
		wait_drained();

		// full-scale lengths, then short ones to finish the frame
		set_config(65535, 65535, 1, 0, rand_byte(), rand_byte());
		w = '1;
		queue_word(w);
		queue_ticks(3);
		wait_drained();
		set_config(1, 0, 0, 1, 0, 255);
		queue_ticks(frame_ticks());
		queue_ticks(4);
		wait_drained();

		start = words_queued;
		while (words_queued - start < RANDOM_WORDS) begin
			set_config(rand_len(), rand_len(), rand_len(), rand_len(), rand_byte(), rand_byte());
			if ($urandom_range(0, 1) == 1) queue_ticks($urandom_range(1, 3));
			queue_frame(random_reading(FUNC_SEND));
			queue_ticks($urandom_range(0, 3));
			wait_drained();
		end

		$display("checked %0d result words across %0d register settings",
			words_checked, settings_used + 1);
		$display("%0d frames sent to the end, %0d sends refused while busy",
			frames_done, rejects_seen);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
